FILE: hw/rtl/polynomial_phase_phasor_cascade_defines.svh
// Assertion macros used by the phasor cascade checker.
`ifndef POLYNOMIAL_PHASE_PHASOR_CASCADE_DEFINES_SVH
`define POLYNOMIAL_PHASE_PHASOR_CASCADE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PPC_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Next-cycle implication: expr must hold in the cycle after trig
`define PPC_ASSERT_NEXT(name, trig, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) trig |=> expr) else $error(msg);

`endif

FILE: hw/rtl/ppc_pkg.sv
// Types and field widths of the polynomial phase phasor cascade.
package ppc_pkg;

    localparam int FUNC_W   = 1;
    localparam int ORDER_W  = 3;
    localparam int JOINT_W  = 3;
    localparam int SAMPLE_W = 16;
    localparam int DEGREE_W = 3;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_STEP = 1'b1;

    // one phasor word: real in the low half, imaginary in the high half
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] im;
        logic signed [SAMPLE_W-1:0] re;
    } phasor_t;

    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic [ORDER_W-1:0]         target_order;
        logic [JOINT_W-1:0]         target_joint;
        logic signed [SAMPLE_W-1:0] load_real;
        logic signed [SAMPLE_W-1:0] load_imag;
    } cmd_word_t;

    typedef struct packed {
        logic [JOINT_W-1:0]         out_joint;
        logic signed [SAMPLE_W-1:0] cos_value;
        logic signed [SAMPLE_W-1:0] sin_value;
        logic                       last;
    } sample_word_t;

    typedef logic [DEGREE_W-1:0] degree_t;

endpackage

FILE: hw/rtl/ppc_stream_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
interface ppc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ppc_cmul.sv
// Two-stage Q1.15 complex multiplier with round-to-nearest and saturation.
module ppc_cmul (
    input  logic             clk,
    input  ppc_pkg::phasor_t a,
    input  ppc_pkg::phasor_t b,
    output ppc_pkg::phasor_t prod
);
    import ppc_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - (SAMPLE_W - 1);

    logic signed [PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    phasor_t                  prod_reg;
    phasor_t                  prod_next;
    logic signed [SUM_W-1:0]  sum_re, sum_im;

    // Q3.30 sum to Q1.15: add half an LSB, floor shift, clamp
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [SUM_W-1:0] acc
    );
        logic signed [SUM_W-1:0] biased;
        logic signed [Q_W-1:0]   q;
        logic signed [Q_W-1:0]   q_max;
        logic signed [Q_W-1:0]   q_min;
        biased = acc + SUM_W'(signed'(1 <<< (SAMPLE_W - 2)));
        q      = biased[SUM_W-1:SAMPLE_W-1];
        q_max  = Q_W'((1 <<< (SAMPLE_W - 1)) - 1);
        q_min  = -Q_W'(1 <<< (SAMPLE_W - 1));
        priority if (q > q_max)
            round_sat = q_max[SAMPLE_W-1:0];
        else if (q < q_min)
            round_sat = q_min[SAMPLE_W-1:0];
        else
            round_sat = q[SAMPLE_W-1:0];
    endfunction

    // stage 1: four partial products
    always_ff @(posedge clk)
    begin
        p_rr_reg <= a.re * b.re;
        p_ii_reg <= a.im * b.im;
        p_ri_reg <= a.re * b.im;
        p_ir_reg <= a.im * b.re;
    end

    // stage 2: sums, rounding, saturation
    always_comb
    begin
        sum_re       = SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg);
        sum_im       = SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg);
        prod_next.re = round_sat(sum_re);
        prod_next.im = round_sat(sum_im);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

FILE: hw/rtl/polynomial_phase_phasor_cascade.sv
// Top level of the polynomial phase phasor cascade.
//
// Channels: cmd takes load and step words, sample returns one word per
// joint on a step (joint 0 first, last set on the final joint), cfg sets
// the cascade degree (reset value 1, clamped to MAX_ORDER).
// A load word writes one phasor; a load outside the store is dropped.
// A step reads the order-0 phasor of each joint from the phasor memory,
// then advances deg * JOINTS phasors, each by read, read, multiply,
// round and write back. The phasor memory has a single read port; cmd
// is not ready during a step. The sample output register lets the last
// word of a step wait while the advance runs and the next command is
// taken. If the sink stalls, the emission pauses with the word held.
// Reset clears the controller and the output valid; the phasor memory
// is undefined until loaded.
module polynomial_phase_phasor_cascade #(
    parameter int JOINTS    = 7,
    parameter int MAX_ORDER = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    ppc_stream_if.sink    cfg,
    ppc_stream_if.sink    cmd,
    ppc_stream_if.source  sample
);
    import ppc_pkg::*;

    localparam int DEPTH  = JOINTS * (MAX_ORDER + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DEG_W  = $clog2(MAX_ORDER + 1);

    // controller states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EMIT_RD  = 3'd1;
    localparam logic [2:0] S_EMIT_CAP = 3'd2;
    localparam logic [2:0] S_UPD_RA   = 3'd3;
    localparam logic [2:0] S_UPD_RB   = 3'd4;
    localparam logic [2:0] S_UPD_MUL  = 3'd5;
    localparam logic [2:0] S_UPD_WAIT = 3'd6;
    localparam logic [2:0] S_UPD_WR   = 3'd7;

    phasor_t            mem [DEPTH];
    phasor_t            rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    phasor_t            wr_data;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  lim_reg, lim_next;
    logic               upd_en_reg, upd_en_next;
    degree_t            degree_reg;
    phasor_t            a_reg, a_next;
    phasor_t            prod;

    logic               out_valid_reg, out_valid_next;
    sample_word_t       out_data_reg, out_data_next;

    logic               cmd_fire;
    logic               load_ok;
    logic [ADDR_W-1:0]  load_addr;
    logic [DEG_W-1:0]   deg_sat;
    logic               out_free;
    logic               emit_last;
    logic               upd_last;

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            degree_reg <= degree_t'(1);
        else if (cfg.valid)
            degree_reg <= cfg.data;
    end

    // phasor memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    ppc_cmul u_cmul (
        .clk  (clk),
        .a    (a_reg),
        .b    (rd_data_reg),
        .prod (prod)
    );

    // command decode
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign load_ok   = (int'(cmd.data.target_order) <= MAX_ORDER) &&
                       (int'(cmd.data.target_joint) < JOINTS);
    assign load_addr = ADDR_W'(int'(cmd.data.target_order) * JOINTS +
                               int'(cmd.data.target_joint));
    assign deg_sat   = (int'(degree_reg) > MAX_ORDER) ? DEG_W'(MAX_ORDER)
                                                      : DEG_W'(degree_reg);

    assign out_free  = !out_valid_reg || sample.ready;
    assign emit_last = (int'(cnt_reg) == JOINTS - 1);
    assign upd_last  = (cnt_reg == lim_reg);

    // read address per state; the b operand sits one order above a
    always_comb
    begin
        unique case (state_reg)
            S_UPD_RB: rd_addr = cnt_reg + ADDR_W'(JOINTS);
            default:  rd_addr = cnt_reg;
        endcase
    end

    // controller
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        upd_en_next    = upd_en_reg;
        a_next         = a_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_data        = prod;

        if (out_valid_reg && sample.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.data.func == FUNC_STEP)
                    begin
                        cnt_next    = '0;
                        upd_en_next = (deg_sat != '0);
                        lim_next    = ADDR_W'(int'(deg_sat) * JOINTS - 1);
                        state_next  = S_EMIT_RD;
                    end
                    else
                    begin
                        wr_en      = load_ok;
                        wr_addr    = load_addr;
                        wr_data.re = cmd.data.load_real;
                        wr_data.im = cmd.data.load_imag;
                    end
                end
            end
            S_EMIT_RD:
            begin
                // read only once the output register frees up
                if (out_free)
                    state_next = S_EMIT_CAP;
            end
            S_EMIT_CAP:
            begin
                out_valid_next          = 1'b1;
                out_data_next.out_joint = JOINT_W'(cnt_reg);
                out_data_next.cos_value = rd_data_reg.re;
                out_data_next.sin_value = rd_data_reg.im;
                out_data_next.last      = emit_last;
                if (emit_last)
                begin
                    cnt_next   = '0;
                    state_next = upd_en_reg ? S_UPD_RA : S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_EMIT_RD;
                end
            end
            S_UPD_RA:
            begin
                state_next = S_UPD_RB;
            end
            S_UPD_RB:
            begin
                a_next     = rd_data_reg;
                state_next = S_UPD_MUL;
            end
            S_UPD_MUL:
            begin
                state_next = S_UPD_WAIT;
            end
            S_UPD_WAIT:
            begin
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                // orders are walked upward, so order m+1 is still old here
                wr_en = 1'b1;
                if (upd_last)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_UPD_RA;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            lim_reg       <= '0;
            upd_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lim_reg       <= lim_next;
            upd_en_reg    <= upd_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        out_data_reg <= out_data_next;
    end

    assign sample.valid = out_valid_reg;
    assign sample.data  = out_data_reg;

endmodule

FILE: hw/rtl/ppc_checker.sv
// Port-level checks of the phasor cascade, bound to its top level.
`include "polynomial_phase_phasor_cascade_defines.svh"

module ppc_checker #(
    parameter int JOINTS = 7
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_ready,
    input logic                  sample_valid,
    input logic                  sample_ready,
    input ppc_pkg::sample_word_t sample_data
);
    import ppc_pkg::*;

    // a stalled word stays offered and unchanged
    `PPC_ASSERT_NEXT(a_sample_hold, sample_valid && !sample_ready, sample_valid, "sample word dropped while stalled")
    `PPC_ASSERT_NEXT(a_sample_stable, sample_valid && !sample_ready, $stable(sample_data), "sample word changed while stalled")

    // last marks the final joint of a step
    `PPC_ASSERT(a_last_joint, sample_valid && sample_data.last |-> sample_data.out_joint == JOINT_W'(JOINTS - 1), "last on wrong joint")

    // no new command while a step is still emitting
    `PPC_ASSERT(a_no_cmd_mid_step, sample_valid && !sample_data.last |-> !cmd_ready, "command ready in the middle of a step")

endmodule

bind polynomial_phase_phasor_cascade ppc_checker #(
    .JOINTS (JOINTS)
) u_ppc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_ready    (cmd.ready),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .sample_data  (sample.data)
);

FILE: bench/tb.sv
// Testbench for the polynomial phase phasor cascade: driver, monitor and predictor.
`timescale 1ns / 1ps

module tb;
    import ppc_pkg::*;

    localparam int JOINTS        = 7;
    localparam int MAX_ORDER     = 5;
    localparam int SETTLE_CYCLES = 220;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 26;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ppc_stream_if #(.payload_t(degree_t))      cfg_bus ();
    ppc_stream_if #(.payload_t(cmd_word_t))    cmd_bus ();
    ppc_stream_if #(.payload_t(sample_word_t)) sample_bus ();

    polynomial_phase_phasor_cascade #(
        .JOINTS    (JOINTS),
        .MAX_ORDER (MAX_ORDER)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .cmd    (cmd_bus),
        .sample (sample_bus)
    );

    always #5 clk = ~clk;

    // phasor store as the block should hold it, plus the degree in force
    phasor_t      phasor_model [0:MAX_ORDER][0:JOINTS-1];
    degree_t      degree_model = degree_t'(1);
    sample_word_t expected_samples [$];

    // stimulus bookkeeping
    cmd_word_t cmd_pending [$];
    bit        loaded [0:MAX_ORDER][0:JOINTS-1];
    degree_t   degree_now = degree_t'(1);
    int        cmds_queued = 0;
    int        cmds_taken = 0;
    logic      cmd_taken = 1'b0;
    int        cmd_gap = 0;
    int        sink_stall = 0;
    bit        idle_on = 1'b1;
    int        mismatches = 0;
    int        cycles = 0;

    // Q3.30 sum to Q1.15: round to nearest, ties up, then saturate
    function automatic logic signed [SAMPLE_W-1:0] round_q15(longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> 15;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic phasor_t phasor_mul(phasor_t a, phasor_t b);
        longint  re_acc;
        longint  im_acc;
        phasor_t r;
        re_acc = longint'(a.re) * longint'(b.re) - longint'(a.im) * longint'(b.im);
        im_acc = longint'(a.re) * longint'(b.im) + longint'(a.im) * longint'(b.re);
        r.re = round_q15(re_acc);
        r.im = round_q15(im_acc);
        return r;
    endfunction

    function automatic int clamp_degree(degree_t d);
        return (int'(d) > MAX_ORDER) ? MAX_ORDER : int'(d);
    endfunction

    // Advance the model by one accepted command word
    task automatic apply_command(cmd_word_t c);
        int           deg;
        sample_word_t s;
        phasor_t      p;
        if (c.func == FUNC_LOAD)
        begin
            if (c.target_order <= MAX_ORDER && c.target_joint < JOINTS)
            begin
                p.re = c.load_real;
                p.im = c.load_imag;
                phasor_model[c.target_order][c.target_joint] = p;
            end
        end
        else
        begin
            for (int j = 0; j < JOINTS; j++)
            begin
                s.out_joint = j[JOINT_W-1:0];
                s.cos_value = phasor_model[0][j].re;
                s.sin_value = phasor_model[0][j].im;
                s.last      = (j == JOINTS - 1);
                expected_samples = {expected_samples, s};
            end
            // ascending order: order m+1 is still the old value when m is updated
            deg = clamp_degree(degree_model);
            for (int m = 0; m < deg; m++)
                for (int j = 0; j < JOINTS; j++)
                    phasor_model[m][j] = phasor_mul(phasor_model[m][j],
                                                    phasor_model[m+1][j]);
        end
    endtask

    // Monitor: acceptance on cmd and cfg, checking on sample
    always @(posedge clk)
    begin : monitor
        sample_word_t want;
        sample_word_t got;
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
        end
        else
        begin
            cmd_taken <= cmd_bus.valid && cmd_bus.ready;
            if (cfg_bus.valid && cfg_bus.ready)
                degree_model = cfg_bus.data;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                apply_command(cmd_bus.data);
                cmds_taken++;
            end
            if (sample_bus.valid && sample_bus.ready)
            begin
                got = sample_bus.data;
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word: joint %0d cos %0d sin %0d last %0b",
                             $time, got.out_joint, got.cos_value, got.sin_value, got.last);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got.out_joint !== want.out_joint || got.cos_value !== want.cos_value
                        || got.sin_value !== want.sin_value || got.last !== want.last)
                    begin
                        mismatches++;
                        $display({"%0t: word mismatch: expected joint %0d cos %0d sin %0d",
                                  " last %0b, got joint %0d cos %0d sin %0d last %0b"},
                                 $time, want.out_joint, want.cos_value, want.sin_value,
                                 want.last, got.out_joint, got.cos_value, got.sin_value,
                                 got.last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Command driver: holds a word until taken, random gaps between words
    always @(negedge clk)
    begin : cmd_driver
        cmd_word_t nxt_word;
        logic      nxt_valid;
        nxt_word  = cmd_bus.data;
        nxt_valid = cmd_bus.valid;
        if (!rst_n)
        begin
            nxt_valid = 1'b0;
        end
        else if (!cmd_bus.valid || cmd_taken)
        begin
            nxt_valid = 1'b0;
            if (cmd_gap != 0)
            begin
                cmd_gap--;
            end
            else if (cmd_pending.size() != 0)
            begin
                if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    cmd_gap = $urandom_range(0, 16);
                end
                else
                begin
                    nxt_word  = cmd_pending.pop_front();
                    nxt_valid = 1'b1;
                end
            end
        end
        cmd_bus.valid <= nxt_valid;
        cmd_bus.data  <= nxt_word;
    end

    // Sample sink: random stall bursts
    always @(negedge clk)
    begin : sink_driver
        logic nxt_ready;
        nxt_ready = 1'b1;
        if (!rst_n)
        begin
            nxt_ready = 1'b0;
        end
        else if (sink_stall != 0)
        begin
            nxt_ready = 1'b0;
            sink_stall--;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            nxt_ready  = 1'b0;
            sink_stall = $urandom_range(0, 16);
        end
        sample_bus.ready <= nxt_ready;
    end

    task automatic queue_command(logic [FUNC_W-1:0] func, int order, int joint, int re, int im);
        cmd_word_t c;
        c.func         = func;
        c.target_order = order[ORDER_W-1:0];
        c.target_joint = joint[JOINT_W-1:0];
        c.load_real    = re[SAMPLE_W-1:0];
        c.load_imag    = im[SAMPLE_W-1:0];
        cmd_pending = {cmd_pending, c};
        cmds_queued++;
        if (func == FUNC_LOAD && order <= MAX_ORDER && joint < JOINTS)
            loaded[order][joint] = 1'b1;
    endtask

    function automatic int pick_sample();
        int corner [6] = '{-32768, -32767, -1, 0, 1, 32767};
        if ($urandom_range(0, 7) == 0)
            return corner[$urandom_range(0, 5)];
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Load every entry that the next step will read and that was never written
    task automatic fill_missing();
        int deg;
        deg = clamp_degree(degree_now);
        for (int m = 0; m <= deg; m++)
            for (int j = 0; j < JOINTS; j++)
                if (!loaded[m][j])
                    queue_command(FUNC_LOAD, m, j, pick_sample(), pick_sample());
    endtask

    // Step word; the unused fields carry random bits
    task automatic queue_step();
        fill_missing();
        queue_command(FUNC_STEP, $urandom_range(0, 7), $urandom_range(0, 7),
                      pick_sample(), pick_sample());
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (cmds_taken != cmds_queued || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_degree(int d);
        wait_idle();
        cfg_bus.data  <= degree_t'(d);
        cfg_bus.valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready));
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        degree_now = degree_t'(d);
    endtask

    // Random mix: steps, single loads, dropped loads, and reseed-then-step runs
    task automatic random_phase(int n);
        int count;
        int deg;
        int joint;
        int steps;
        count = 0;
        deg   = clamp_degree(degree_now);
        while (count < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    queue_step();
                    count++;
                end
                5, 6:
                begin
                    queue_command(FUNC_LOAD, $urandom_range(0, MAX_ORDER),
                                  $urandom_range(0, JOINTS - 1), pick_sample(), pick_sample());
                    count++;
                end
                7:
                begin
                    if ($urandom_range(0, 1) == 0)
                        queue_command(FUNC_LOAD, $urandom_range(MAX_ORDER + 1, 7),
                                      $urandom_range(0, 7), pick_sample(), pick_sample());
                    else
                        queue_command(FUNC_LOAD, $urandom_range(0, 7), JOINTS,
                                      pick_sample(), pick_sample());
                    count++;
                end
                default:
                begin
                    joint = $urandom_range(0, JOINTS - 1);
                    steps = $urandom_range(1, 3);
                    for (int m = 0; m <= deg; m++)
                        queue_command(FUNC_LOAD, m, joint, pick_sample(), pick_sample());
                    repeat (steps) queue_step();
                    count += deg + 1 + steps;
                end
            endcase
        end
    endtask

    initial
    begin
        // corner pairs: saturation of (-1)*(-1), rounding ties both signs
        int o0_re [JOINTS] = '{-32768, -32768, 32767, 1, -1, 0, 32767};
        int o0_im [JOINTS] = '{0, -32768, 32767, 0, 0, 32767, 0};
        int o1_re [JOINTS] = '{-32768, -32768, 32767, 16384, 16384, 0, 32767};
        int o1_im [JOINTS] = '{0, -32768, -32768, 0, 0, 32767, 0};
        int plan [8] = '{5, 7, 3, 6, 2, 4, 1, 5};

        cfg_bus.valid    = 1'b0;
        cfg_bus.data     = '0;
        cmd_bus.valid    = 1'b0;
        cmd_bus.data     = '0;
        sample_bus.ready = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset degree, corner values, dropped loads
        for (int j = 0; j < JOINTS; j++)
        begin
            queue_command(FUNC_LOAD, 0, j, o0_re[j], o0_im[j]);
            queue_command(FUNC_LOAD, 1, j, o1_re[j], o1_im[j]);
        end
        queue_command(FUNC_LOAD, MAX_ORDER + 1, 2, 32767, -32768);
        queue_command(FUNC_LOAD, 7, 7, -1, -1);
        queue_command(FUNC_LOAD, 0, JOINTS, 12345, -12345);
        queue_step();
        queue_step();

        // degree zero: emit only
        write_degree(0);
        queue_step();

        // random phases over several degrees, the clamped ones among them
        foreach (plan[p])
        begin
            write_degree(plan[p]);
            idle_on = (p != 7) && ($urandom_range(0, 3) != 0);
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
